@@ hw/rtl/hre_pkg.sv @@
// hre_pkg: shared types, constants and helpers for the hex record encoder
// used by hre_ctrl, hre_dp, hex_record_encoder_core and hre_checker
// no dependencies
package hre_pkg;

  localparam int BYTES_PER_RECORD = 16;
  localparam int BUF_DEPTH        = 16;
  localparam int PTR_W            = $clog2(BUF_DEPTH);
  localparam int CNT_W            = PTR_W + 1;

  localparam logic [1:0] MODE_DATA  = 2'd0;
  localparam logic [1:0] MODE_ADDR  = 2'd1;
  localparam logic [1:0] MODE_CLOSE = 2'd2;

  localparam logic FMT_INTEL = 1'b0;
  localparam logic FMT_SREC  = 1'b1;

  localparam logic [7:0] CHR_COLON = 8'h3A;
  localparam logic [7:0] CHR_S     = 8'h53;
  localparam logic [7:0] CHR_ONE   = 8'h31;
  localparam logic [7:0] CHR_NINE  = 8'h39;
  localparam logic [7:0] CHR_NL    = 8'h0A;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MARK,
    ST_KIND,
    ST_HI,
    ST_LO,
    ST_NL
  } state_t;

  typedef enum logic [2:0] {
    FLD_COUNT,
    FLD_ADDRH,
    FLD_ADDRL,
    FLD_TYPE,
    FLD_DATA,
    FLD_SUM
  } field_t;

  typedef enum logic [2:0] {
    CH_MARK,
    CH_KIND,
    CH_HI,
    CH_LO,
    CH_NL
  } char_sel_t;

  typedef struct packed {
    logic      push;
    logic      take_addr;
    logic      hold_addr;
    logic      set_addr;
    logic      emit;
    char_sel_t ch_sel;
    field_t    fld;
    logic      end_rec;
    logic      last;
    logic      byte_done;
    logic      rec_done;
  } dp_cmd_t;

  typedef struct packed {
    logic almost_full;
    logic nonempty;
    logic ptr_last;
    logic out_free;
    logic fmt;
  } dp_stat_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] wide;
    wide = {4'h0, nib};
    if (nib < 4'd10) begin
      hex_char = 8'h30 + wide;
    end else begin
      hex_char = 8'h37 + wide;
    end
  endfunction

endpackage

@@ hw/rtl/hre_ctrl.sv @@
// hre_ctrl: sequencer that walks each record field by field, one char a cycle while the output is free
// depends on hre_pkg; drives hre_dp through dp_cmd_t and reads dp_stat_t
module hre_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       mode,
  input  hre_pkg::dp_stat_t st,
  output hre_pkg::dp_cmd_t  cmd
);
  import hre_pkg::*;

  state_t state, state_next;
  field_t fld, fld_next;
  logic   end_rec, end_rec_next;
  logic   then_end, then_end_next;
  logic   then_addr, then_addr_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      fld       <= FLD_COUNT;
      end_rec   <= 1'b0;
      then_end  <= 1'b0;
      then_addr <= 1'b0;
    end else begin
      state     <= state_next;
      fld       <= fld_next;
      end_rec   <= end_rec_next;
      then_end  <= then_end_next;
      then_addr <= then_addr_next;
    end
  end

  always_comb begin
    state_next     = state;
    fld_next       = fld;
    end_rec_next   = end_rec;
    then_end_next  = then_end;
    then_addr_next = then_addr;
    cmd            = '0;
    cmd.fld        = fld;
    cmd.end_rec    = end_rec;
    cmd.ch_sel     = CH_NL;
    in_stall       = (state != ST_IDLE);

    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          case (mode)
            MODE_DATA: begin
              cmd.push = 1'b1;
              if (st.almost_full) begin
                end_rec_next   = 1'b0;
                then_end_next  = 1'b0;
                then_addr_next = 1'b0;
                state_next     = ST_MARK;
              end
            end
            MODE_ADDR: begin
              if (st.nonempty) begin
                cmd.hold_addr  = 1'b1;
                end_rec_next   = 1'b0;
                then_end_next  = 1'b0;
                then_addr_next = 1'b1;
                state_next     = ST_MARK;
              end else begin
                cmd.take_addr = 1'b1;
              end
            end
            MODE_CLOSE: begin
              // flush open bytes first, then the end record
              end_rec_next   = !st.nonempty;
              then_end_next  = st.nonempty;
              then_addr_next = 1'b0;
              state_next     = ST_MARK;
            end
            default: ;
          endcase
        end
      end
      ST_MARK: begin
        cmd.ch_sel = CH_MARK;
        if (st.out_free) begin
          cmd.emit   = 1'b1;
          fld_next   = FLD_COUNT;
          state_next = (st.fmt == FMT_SREC) ? ST_KIND : ST_HI;
        end
      end
      ST_KIND: begin
        cmd.ch_sel = CH_KIND;
        if (st.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_HI;
        end
      end
      ST_HI: begin
        cmd.ch_sel = CH_HI;
        if (st.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_LO;
        end
      end
      ST_LO: begin
        cmd.ch_sel = CH_LO;
        if (st.out_free) begin
          cmd.emit      = 1'b1;
          cmd.byte_done = 1'b1;
          state_next    = ST_HI;
          case (fld)
            FLD_COUNT: fld_next = FLD_ADDRH;
            FLD_ADDRH: fld_next = FLD_ADDRL;
            FLD_ADDRL: begin
              if (st.fmt == FMT_SREC) begin
                fld_next = end_rec ? FLD_SUM : FLD_DATA;
              end else begin
                fld_next = FLD_TYPE;
              end
            end
            FLD_TYPE:  fld_next = end_rec ? FLD_SUM : FLD_DATA;
            FLD_DATA: begin
              if (st.ptr_last) begin
                fld_next = FLD_SUM;
              end
            end
            FLD_SUM:   state_next = ST_NL;
            default:   fld_next = FLD_COUNT;
          endcase
        end
      end
      ST_NL: begin
        cmd.ch_sel = CH_NL;
        cmd.last   = !then_end;
        if (st.out_free) begin
          cmd.emit     = 1'b1;
          cmd.rec_done = 1'b1;
          if (then_end) begin
            end_rec_next  = 1'b1;
            then_end_next = 1'b0;
            state_next    = ST_MARK;
          end else begin
            cmd.set_addr   = then_addr;
            then_addr_next = 1'b0;
            state_next     = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

@@ hw/rtl/hre_dp.sv @@
// hre_dp: byte buffer, address and checksum registers, char select, output register
// depends on hre_pkg; commanded by hre_ctrl
module hre_dp (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wen,
  input  logic              cfg_wdata,
  input  logic [7:0]        data_byte,
  input  logic [15:0]       load_address,
  input  hre_pkg::dp_cmd_t  cmd,
  output hre_pkg::dp_stat_t st,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_char,
  output logic              last
);
  import hre_pkg::*;

  logic [7:0]       byte_buffer [BUF_DEPTH];
  logic [7:0]       rd_byte;
  logic [CNT_W-1:0] byte_count;
  logic [PTR_W-1:0] ptr, ptr_next;
  logic [15:0]      record_address;
  logic [15:0]      pend_addr;
  logic [7:0]       running_sum;
  logic             fmt;

  logic [CNT_W-1:0] rec_len;
  logic [7:0]       len_byte;
  logic [7:0]       cur_byte;
  logic [7:0]       char_sel;
  logic             out_free;

  assign rec_len  = cmd.end_rec ? '0 : byte_count;
  assign len_byte = {{(8-CNT_W){1'b0}}, rec_len};
  assign out_free = !out_valid || !out_stall;

  assign st.almost_full = (byte_count == CNT_W'(BYTES_PER_RECORD - 1));
  assign st.nonempty    = (byte_count != '0);
  assign st.ptr_last    = (({1'b0, ptr} + CNT_W'(1)) == byte_count);
  assign st.out_free    = out_free;
  assign st.fmt         = fmt;

  always_comb begin
    case (cmd.fld)
      FLD_COUNT: cur_byte = (fmt == FMT_SREC) ? len_byte + 8'd3 : len_byte;
      FLD_ADDRH: cur_byte = record_address[15:8];
      FLD_ADDRL: cur_byte = record_address[7:0];
      FLD_TYPE:  cur_byte = {7'b0, cmd.end_rec};
      FLD_DATA:  cur_byte = rd_byte;
      FLD_SUM:   cur_byte = (fmt == FMT_SREC) ? ~running_sum : 8'd0 - running_sum;
      default:   cur_byte = 8'd0;
    endcase
  end

  always_comb begin
    case (cmd.ch_sel)
      CH_MARK: char_sel = (fmt == FMT_SREC) ? CHR_S : CHR_COLON;
      CH_KIND: char_sel = cmd.end_rec ? CHR_NINE : CHR_ONE;
      CH_HI:   char_sel = hex_char(cur_byte[7:4]);
      CH_LO:   char_sel = hex_char(cur_byte[3:0]);
      CH_NL:   char_sel = CHR_NL;
      default: char_sel = CHR_NL;
    endcase
  end

  always_comb begin
    ptr_next = ptr;
    if (cmd.rec_done) begin
      ptr_next = '0;
    end else if (cmd.byte_done && cmd.fld == FLD_DATA) begin
      ptr_next = ptr + PTR_W'(1);
    end
  end

  // read follows the next pointer so rd_byte always matches ptr
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      byte_buffer[byte_count[PTR_W-1:0]] <= data_byte;
    end
    rd_byte <= byte_buffer[ptr_next];
  end

  always_ff @(posedge clk) begin
    if (cmd.hold_addr) begin
      pend_addr <= load_address;
    end
    if (cmd.emit) begin
      out_char <= char_sel;
      last     <= cmd.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count     <= '0;
      ptr            <= '0;
      record_address <= 16'd0;
      running_sum    <= 8'd0;
      fmt            <= FMT_INTEL;
      out_valid      <= 1'b0;
    end else begin
      ptr <= ptr_next;
      if (cfg_wen) begin
        fmt <= cfg_wdata;
      end
      if (cmd.push) begin
        byte_count <= byte_count + CNT_W'(1);
      end
      if (cmd.byte_done) begin
        running_sum <= running_sum + cur_byte;
      end
      if (cmd.rec_done) begin
        byte_count  <= '0;
        running_sum <= 8'd0;
      end
      // a pending load address replaces the advanced one
      if (cmd.take_addr) begin
        record_address <= load_address;
      end else if (cmd.set_addr) begin
        record_address <= pend_addr;
      end else if (cmd.rec_done) begin
        record_address <= record_address + {{(16-CNT_W){1'b0}}, rec_len};
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ hw/rtl/hex_record_encoder_core.sv @@
// channel   direction  payload                          handshake
// in        input      mode, data_byte, load_address    in_valid / in_stall
// out       output     out_char, last                   out_valid / out_stall
// cfg       input      cfg_wdata (record format)        cfg_wen
//
// a data byte that does not fill the buffer or an address set on an empty
// buffer does not stall the input; a record goes out at one char per cycle
// through the output register while out_stall is low: 12+2n chars in intel
// form, 11+2n in s1 form (n data bytes), with the input stalled meanwhile.
// close adds an end record (12 intel, 11 s9 chars). out_stall just pauses the
// sequencer. synchronous reset clears counters, address, sum and format.
//
// hex_record_encoder_core: top level, joins hre_ctrl and hre_dp
// depends on hre_pkg, hre_ctrl, hre_dp
module hex_record_encoder_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wen,
  input  logic        cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  mode,
  input  logic [7:0]  data_byte,
  input  logic [15:0] load_address,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_char,
  output logic        last
);
  import hre_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t st;

  hre_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .mode     (mode),
    .st       (st),
    .cmd      (cmd)
  );

  hre_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_wen      (cfg_wen),
    .cfg_wdata    (cfg_wdata),
    .data_byte    (data_byte),
    .load_address (load_address),
    .cmd          (cmd),
    .st           (st),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_char     (out_char),
    .last         (last)
  );

endmodule

@@ hw/rtl/hre_checker.sv @@
// hre_port_checker: port level assertions for hex_record_encoder_core, plus its bind
// depends on hre_pkg and hex_record_encoder_core
module hre_port_checker (
  input logic        clk,
  input logic        rst,
  input logic        cfg_wen,
  input logic        cfg_wdata,
  input logic        in_valid,
  input logic        in_stall,
  input logic [1:0]  mode,
  input logic [7:0]  data_byte,
  input logic [15:0] load_address,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  out_char,
  input logic        last
);
  import hre_pkg::*;

  // a held result keeps its char and flag
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_char) && $stable(last))
    else $error("stalled output changed");

  // the last flag only ever marks a newline char
  a_last_nl: assert property (@(posedge clk) disable iff (rst)
    out_valid && last |-> out_char == CHR_NL)
    else $error("last flag on a char other than newline");

  // close always produces an end record, so the input is held
  a_close_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && mode == MODE_CLOSE |=> in_stall)
    else $error("close accepted without a record");

  // the unused mode does nothing
  a_unused_idle: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && mode != MODE_DATA && mode != MODE_ADDR &&
    mode != MODE_CLOSE |=> !in_stall)
    else $error("unused mode started a record");

endmodule

bind hex_record_encoder_core hre_port_checker u_hre_port_checker (.*);

@@ tb/hre_checker.sv @@
// hre_checker: predicts the record text of the hex record encoder and checks its output
// watches the cfg, input and output channels of hex_record_encoder_core
// depends on hre_pkg
module hre_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wen,
  input  logic        cfg_wdata,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  mode,
  input  logic [7:0]  data_byte,
  input  logic [15:0] load_address,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  out_char,
  input  logic        last,
  output int          mismatch_count,
  output int          pending
);

  timeunit 1ns;
  timeprecision 1ps;

  import hre_pkg::*;

  localparam logic [7:0] REC_DATA = 8'h00;
  localparam logic [7:0] REC_END  = 8'h01;

  // predictor state
  logic [7:0]  byte_store [BUF_DEPTH];
  logic [4:0]  fill;
  logic [15:0] load_ptr;
  logic [7:0]  csum;
  logic        fmt;

  logic [7:0] exp_char [$];
  bit         exp_last [$];
  int         err_n;

  function automatic logic [7:0] ascii_hex(input logic [3:0] nib);
    if (nib < 4'd10) begin
      return 8'h30 + {4'h0, nib};
    end
    return 8'h41 + {4'h0, nib} - 8'd10;
  endfunction

  function automatic void push_char(input logic [7:0] c);
    exp_char.push_back(c);
    exp_last.push_back(1'b0);
  endfunction

  function automatic void push_hex_byte(input logic [7:0] b);
    push_char(ascii_hex(b[7:4]));
    push_char(ascii_hex(b[3:0]));
    csum = csum + b;
  endfunction

  function automatic void queue_record(input bit end_rec);
    logic [4:0] n;
    n = end_rec ? 5'd0 : fill;
    if (fmt == FMT_SREC) begin
      push_char(CHR_S);
      push_char(end_rec ? CHR_NINE : CHR_ONE);
      push_hex_byte({3'b000, n} + 8'd3);
      push_hex_byte(load_ptr[15:8]);
      push_hex_byte(load_ptr[7:0]);
      for (int i = 0; i < n; i++) push_hex_byte(byte_store[i]);
      push_hex_byte(~csum);
    end else begin
      push_char(CHR_COLON);
      push_hex_byte({3'b000, n});
      push_hex_byte(load_ptr[15:8]);
      push_hex_byte(load_ptr[7:0]);
      push_hex_byte(end_rec ? REC_END : REC_DATA);
      for (int i = 0; i < n; i++) push_hex_byte(byte_store[i]);
      push_hex_byte(8'd0 - csum);
    end
    push_char(CHR_NL);
    load_ptr = load_ptr + {11'd0, n};
    fill = 5'd0;
    csum = 8'd0;
  endfunction

  function automatic void predict_item(input logic [1:0] m, input logic [7:0] d,
                                       input logic [15:0] a);
    int n_start;
    n_start = exp_char.size();
    case (m)
      MODE_DATA: begin
        byte_store[fill[PTR_W-1:0]] = d;
        fill = fill + 5'd1;
        if (fill >= BYTES_PER_RECORD) queue_record(1'b0);
      end
      MODE_ADDR: begin
        if (fill != 5'd0) queue_record(1'b0);
        load_ptr = a;
      end
      MODE_CLOSE: begin
        if (fill != 5'd0) queue_record(1'b0);
        queue_record(1'b1);
      end
      default: ;
    endcase
    if (exp_char.size() > n_start) exp_last[exp_last.size()-1] = 1'b1;
  endfunction

  always @(posedge clk) begin
    logic [7:0] want_char;
    bit         want_last;
    if (rst) begin
      fill = 5'd0;
      load_ptr = 16'd0;
      csum = 8'd0;
      fmt = FMT_INTEL;
      err_n = 0;
      exp_char.delete();
      exp_last.delete();
    end else begin
      if (cfg_wen) fmt = cfg_wdata;
      // predict before checking so a same-edge result always finds its entry
      if (in_valid && !in_stall) predict_item(mode, data_byte, load_address);
      if (out_valid && !out_stall) begin
        if (exp_char.size() == 0) begin
          err_n++;
          $display("%0t: unexpected char expected none actual %h last %b",
                   $time, out_char, last);
        end else begin
          want_char = exp_char.pop_front();
          want_last = exp_last.pop_front();
          if (out_char !== want_char) begin
            err_n++;
            $display("%0t: out_char expected %h actual %h", $time, want_char, out_char);
          end
          if (last !== want_last) begin
            err_n++;
            $display("%0t: last expected %b actual %b", $time, want_last, last);
          end
        end
      end
    end
    mismatch_count <= err_n;
    pending <= exp_char.size();
  end

endmodule

@@ tb/tb_hex_record_encoder_core.sv @@
// tb_hex_record_encoder_core: stimulus, idling and verdict for hex_record_encoder_core
// directed and random byte / address / close items in both record formats
// depends on hre_pkg, hex_record_encoder_core and hre_checker
module tb_hex_record_encoder_core;

  timeunit 1ns;
  timeprecision 1ps;

  import hre_pkg::*;

  localparam logic [1:0] MODE_NONE   = 2'd3;
  localparam int         CYCLE_LIMIT = 1000000;
  localparam int         SETTLE      = 8;
  localparam int         SEG_ITEMS   = 58;

  logic        clk;
  logic        rst;
  logic        cfg_wen;
  logic        cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  mode;
  logic [7:0]  data_byte;
  logic [15:0] load_address;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_char;
  logic        last;

  int mismatch_count;
  int pending;
  int snd_idle_pct;
  int rcv_idle_pct;
  int items_sent;
  int cycle_count = 0;

  hex_record_encoder_core i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wen     (cfg_wen),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .mode        (mode),
    .data_byte   (data_byte),
    .load_address(load_address),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_char    (out_char),
    .last        (last)
  );

  hre_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_wen       (cfg_wen),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .mode          (mode),
    .data_byte     (data_byte),
    .load_address  (load_address),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_char      (out_char),
    .last          (last),
    .mismatch_count(mismatch_count),
    .pending       (pending)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < rcv_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_hex_record_encoder_core failed");
      $finish;
    end
  end

  task automatic send_item(input logic [1:0] m, input logic [7:0] d, input logic [15:0] a);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= m;
    data_byte <= d;
    load_address <= a;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (m != MODE_NONE) items_sent++;
  endtask

  // pending is registered in the checker, so always step at least once
  task automatic wait_drained();
    do begin
      @(posedge clk);
    end while (pending != 0);
  endtask

  task automatic drain_and_settle();
    in_valid <= 1'b0;
    wait_drained();
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_format(input logic f);
    cfg_wen <= 1'b1;
    cfg_wdata <= f;
    @(posedge clk);
    cfg_wen <= 1'b0;
  endtask

  function automatic logic [15:0] rand_address();
    // a good share lands just below the wrap point
    if ($urandom_range(3) == 0) return 16'hFFF0 | 16'($urandom_range(15));
    return 16'($urandom);
  endfunction

  // optional address, a burst of bytes with some noise, maybe a close
  task automatic send_sequence();
    int len;
    if ($urandom_range(1) == 1) send_item(MODE_ADDR, 8'($urandom), rand_address());
    if ($urandom_range(99) < 40) begin
      len = 16 * $urandom_range(1, 2);
    end else begin
      len = $urandom_range(1, 20);
    end
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(99) < 4) send_item(MODE_NONE, 8'($urandom), 16'($urandom));
      send_item(MODE_DATA, 8'($urandom), 16'($urandom));
    end
    if ($urandom_range(99) < 35) send_item(MODE_CLOSE, 8'($urandom), 16'($urandom));
  endtask

  initial begin
    int  seg_start;
    bit  paused;
    logic f;
    rst = 1'b1;
    cfg_wen = 1'b0;
    cfg_wdata = 1'b0;
    in_valid = 1'b0;
    mode = MODE_DATA;
    data_byte = 8'h00;
    load_address = 16'h0000;
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    items_sent = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // intel: end record on empty buffer, ignored mode, address set with nothing
    // buffered, flush on address change across the wrap, close with one byte
    write_format(FMT_INTEL);
    send_item(MODE_CLOSE, 8'h00, 16'h0000);
    send_item(MODE_NONE, 8'hFF, 16'hFFFF);
    send_item(MODE_ADDR, 8'h00, 16'hFFFF);
    send_item(MODE_DATA, 8'h00, 16'h0000);
    send_item(MODE_DATA, 8'hFF, 16'hFFFF);
    send_item(MODE_ADDR, 8'hFF, 16'hFFF8);
    send_item(MODE_DATA, 8'hA5, 16'h0000);
    send_item(MODE_CLOSE, 8'hFF, 16'hFFFF);
    drain_and_settle();

    // s1/s9 forms: end record on empty buffer, flush on address change, close with one byte
    write_format(FMT_SREC);
    send_item(MODE_CLOSE, 8'h00, 16'h0000);
    send_item(MODE_DATA, 8'h5A, 16'hFFFF);
    send_item(MODE_ADDR, 8'h00, 16'h0000);
    send_item(MODE_DATA, 8'hFF, 16'h0000);
    send_item(MODE_CLOSE, 8'h00, 16'hFFFF);

    for (int seg = 0; seg < 6; seg++) begin
      drain_and_settle();
      if (seg < 4) begin
        f = logic'(seg % 2);
      end else begin
        f = logic'($urandom_range(1));
      end
      write_format(f);
      if (seg < 2) begin
        snd_idle_pct = 25;
        rcv_idle_pct = 87;
      end else if (seg < 4) begin
        snd_idle_pct = 87;
        rcv_idle_pct = 25;
      end else begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end
      seg_start = items_sent;
      paused = 1'b0;
      while (items_sent - seg_start < SEG_ITEMS) begin
        send_sequence();
        // hold the sender off until the output side has caught up
        if (!paused && items_sent - seg_start >= SEG_ITEMS / 2) begin
          in_valid <= 1'b0;
          wait_drained();
          paused = 1'b1;
        end
      end
    end

    in_valid <= 1'b0;
    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && pending == 0) begin
      $display("tb_hex_record_encoder_core passed");
    end else begin
      $display("tb_hex_record_encoder_core failed");
    end
    $finish;
  end

endmodule

@@ hex_record_encoder_core.f @@
hw/rtl/hre_pkg.sv
hw/rtl/hre_ctrl.sv
hw/rtl/hre_dp.sv
hw/rtl/hex_record_encoder_core.sv
hw/rtl/hre_checker.sv
tb/hre_checker.sv
tb/tb_hex_record_encoder_core.sv
